// ===== rtl/ame_pkg.sv =====
// Shared types and constants for the accumulator machine execute stage.
// Opcodes, print kinds, status codes and register file sizing.
// No dependencies.
package ame_pkg;

    localparam int REG_COUNT = 256;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 16;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [DATA_W-1:0]    data_t;

    typedef enum logic [3:0] {
        OP_LOADIMM  = 4'd0,
        OP_STORE    = 4'd1,
        OP_LOADREG  = 4'd2,
        OP_PRINT    = 4'd3,
        OP_PRINTNUM = 4'd4,
        OP_JUMPNZ   = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_ADD      = 4'd8,
        OP_HALT     = 4'd9
    } opcode_t;

    typedef enum logic [1:0] {
        PK_NONE = 2'd0,
        PK_MSG  = 2'd1,
        PK_NUM  = 2'd2
    } print_kind_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_HALT = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

endpackage

// ===== rtl/accumulator_machine_execute_top.sv =====
// Execute stage of a small accumulator machine: accumulator, register file and result register.
// Depends on ame_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one decoded instruction per transfer:
//   mode, immediate, reg_first, reg_second, jump_target.
//   Output channel (out_valid/out_ready) carries one result per instruction:
//   acc_value, branch_taken, branch_address, print_kind, print_value, status.
//   Throughput: one instruction per cycle while the receiver does not stall. The register file is one synchronous
//   memory with two read ports and one write port; operands are read in the
//   cycle of the input transfer and registered with the instruction in the execute stage.
//   The instruction executes from the execute stage registers, and its result is
//   registered in the result register before it is shown on the output channel.
//   A store in the execute cycle is forwarded to an operand read of the same entry.
//   Reset clears the accumulator and a valid bit per register entry, so unwritten
//   entries read as zero at once; no clearing pass is needed.
//   When the receiver stalls, the result register holds, the execute stage holds
//   one more instruction, and in_ready drops once both are full.
module accumulator_machine_execute_top
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [3:0]            mode,
    input  logic [63:0]           immediate,
    input  logic [7:0]            reg_first,
    input  logic [7:0]            reg_second,
    input  logic [15:0]           jump_target,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [63:0]           acc_value,
    output logic                  branch_taken,
    output logic [15:0]           branch_address,
    output logic [1:0]            print_kind,
    output logic [63:0]           print_value,
    output logic [1:0]            status
);
    import ame_pkg::*;

    data_t                  mem [REG_COUNT];
    logic [REG_COUNT-1:0]   vld_reg;

    logic                   s1_valid_reg;
    opcode_t                s1_op_reg;
    data_t                  s1_imm_reg;
    logic [ADDR_W-1:0]      s1_target_reg;
    reg_idx_t               s1_ra_reg;
    data_t                  rd_a_reg;
    data_t                  rd_b_reg;
    logic                   vld_a_reg;
    logic                   vld_b_reg;
    logic                   fwd_a_reg;
    logic                   fwd_b_reg;
    data_t                  fwd_val_reg;

    data_t                  acc_reg;
    data_t                  acc_next;

    logic                   out_valid_reg;
    data_t                  out_acc_reg;
    logic                   out_taken_reg;
    logic [ADDR_W-1:0]      out_addr_reg;
    print_kind_t            out_pkind_reg;
    data_t                  out_pval_reg;
    status_t                out_status_reg;

    logic                   in_fire;
    logic                   s1_fire;
    logic                   s1_store;
    reg_idx_t               in_ra;
    reg_idx_t               in_rb;
    data_t                  opnd_a;
    data_t                  opnd_b;
    data_t                  res_acc;
    logic                   res_taken;
    logic [ADDR_W-1:0]      res_addr;
    print_kind_t            res_pkind;
    data_t                  res_pval;
    status_t                res_status;

    assign in_ra    = REG_IDX_W'(reg_first);
    assign in_rb    = REG_IDX_W'(reg_second);
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;
    assign s1_store = s1_fire && (s1_op_reg == OP_STORE);

    // operand select: forwarded store, then memory, then reset value
    assign opnd_a = fwd_a_reg ? fwd_val_reg : (vld_a_reg ? rd_a_reg : '0);
    assign opnd_b = fwd_b_reg ? fwd_val_reg : (vld_b_reg ? rd_b_reg : '0);

    always_comb
    begin
        acc_next   = acc_reg;
        res_taken  = 1'b0;
        res_addr   = '0;
        res_pkind  = PK_NONE;
        res_pval   = '0;
        res_status = ST_RUN;
        case (s1_op_reg)
            OP_LOADIMM:  acc_next = s1_imm_reg;
            OP_STORE:    acc_next = acc_reg;
            OP_LOADREG:  acc_next = opnd_a;
            OP_PRINT:
            begin
                res_pkind = PK_MSG;
                res_pval  = s1_imm_reg;
            end
            OP_PRINTNUM:
            begin
                res_pkind = PK_NUM;
                res_pval  = acc_reg;
            end
            OP_JUMPNZ:
            begin
                if (acc_reg != '0)
                begin
                    res_taken = 1'b1;
                    res_addr  = s1_target_reg;
                end
            end
            OP_INC:      acc_next = acc_reg + DATA_W'(1);
            OP_DEC:      acc_next = acc_reg - DATA_W'(1);
            OP_ADD:      acc_next = opnd_a + opnd_b;
            OP_HALT:     res_status = ST_HALT;
            default:     res_status = ST_BAD;
        endcase
        res_acc = (res_status == ST_BAD) ? '0 : acc_next;
    end

    // register file: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (s1_store)
        begin
            mem[s1_ra_reg] <= acc_reg;
        end
        if (in_fire)
        begin
            rd_a_reg <= mem[in_ra];
            rd_b_reg <= mem[in_rb];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (s1_store)
        begin
            vld_reg[s1_ra_reg] <= 1'b1;
        end
    end

    // execute stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg     <= opcode_t'(mode);
            s1_imm_reg    <= immediate;
            s1_target_reg <= jump_target;
            s1_ra_reg     <= in_ra;
            vld_a_reg     <= vld_reg[in_ra];
            vld_b_reg     <= vld_reg[in_rb];
            fwd_a_reg     <= s1_store && (s1_ra_reg == in_ra);
            fwd_b_reg     <= s1_store && (s1_ra_reg == in_rb);
            fwd_val_reg   <= acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                acc_reg       <= acc_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_acc_reg    <= res_acc;
            out_taken_reg  <= res_taken;
            out_addr_reg   <= res_addr;
            out_pkind_reg  <= res_pkind;
            out_pval_reg   <= res_pval;
            out_status_reg <= res_status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign acc_value      = out_acc_reg;
    assign branch_taken   = out_taken_reg;
    assign branch_address = out_addr_reg;
    assign print_kind     = out_pkind_reg;
    assign print_value    = out_pval_reg;
    assign status         = out_status_reg;

    a_bad_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_BAD) |->
            (acc_value == '0) && !branch_taken && (print_kind == PK_NONE))
        else $error("bad opcode result not cleared");

    a_taken_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch_taken |-> (acc_value != '0))
        else $error("branch taken with zero accumulator");

    a_store_marks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_store |=> vld_reg[$past(s1_ra_reg)])
        else $error("store did not mark register entry");

    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |-> !in_ready)
        else $error("transfer accepted while execute stage held");

    a_printnum_acc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (print_kind == PK_NUM) |-> (print_value == acc_value))
        else $error("printed number differs from accumulator");

endmodule

// ===== tb/testbench.sv =====
// Testbench for accumulator_machine_execute_top: directed and random instruction streams.
// Predicts each result with its own accumulator and register file copy; depends on ame_pkg.
// Both channels idle and stall at random, with long output hold-offs to fill the block.
module testbench;

    import ame_pkg::*;

    localparam int          TIMEOUT      = 2_000_000;
    localparam int          RANDOM_ITEMS = 660;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          DRAIN_CYCLES = 10;
    localparam logic [3:0]  OP_BAD_FIRST = 4'd10;
    localparam logic [3:0]  OP_BAD_LAST  = 4'd15;

    typedef struct {
        data_t       acc;
        logic        taken;
        logic [15:0] addr;
        print_kind_t pkind;
        data_t       pval;
        status_t     stat;
    } exec_result_t;

    typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  mode;
    logic [63:0] immediate;
    logic [7:0]  reg_first;
    logic [7:0]  reg_second;
    logic [15:0] jump_target;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] acc_value;
    logic        branch_taken;
    logic [15:0] branch_address;
    logic [1:0]  print_kind;
    logic [63:0] print_value;
    logic [1:0]  status;

    data_t        acc_model;
    data_t        regfile_model [REG_COUNT];
    exec_result_t pending_results [$];
    int           mismatch_count;
    rx_mode_t     rx_mode;
    logic         hold_req;
    logic [7:0]   rx_pattern;

    accumulator_machine_execute_top u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .immediate      (immediate),
        .reg_first      (reg_first),
        .reg_second     (reg_second),
        .jump_target    (jump_target),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .acc_value      (acc_value),
        .branch_taken   (branch_taken),
        .branch_address (branch_address),
        .print_kind     (print_kind),
        .print_value    (print_value),
        .status         (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT);
        $display("Verification failed");
        $finish;
    end

    function automatic exec_result_t execute_instr(logic [3:0] op, data_t imm,
                                                   logic [7:0] ra_raw, logic [7:0] rb_raw,
                                                   logic [15:0] tgt);
        exec_result_t r;
        int           ra;
        int           rb;
        r  = '{acc: '0, taken: 1'b0, addr: '0, pkind: PK_NONE, pval: '0, stat: ST_RUN};
        ra = ra_raw % REG_COUNT;
        rb = rb_raw % REG_COUNT;
        case (op)
            OP_LOADIMM:  acc_model = imm;
            OP_STORE:    regfile_model[ra] = acc_model;
            OP_LOADREG:  acc_model = regfile_model[ra];
            OP_PRINT:
            begin
                r.pkind = PK_MSG;
                r.pval  = imm;
            end
            OP_PRINTNUM:
            begin
                r.pkind = PK_NUM;
                r.pval  = acc_model;
            end
            OP_JUMPNZ:
            begin
                if (acc_model != '0)
                begin
                    r.taken = 1'b1;
                    r.addr  = tgt;
                end
            end
            OP_INC:      acc_model = acc_model + 64'd1;
            OP_DEC:      acc_model = acc_model - 64'd1;
            OP_ADD:      acc_model = regfile_model[ra] + regfile_model[rb];
            OP_HALT:     r.stat = ST_HALT;
            default:     r.stat = ST_BAD;
        endcase
        r.acc = (r.stat == ST_BAD) ? '0 : acc_model;
        return r;
    endfunction

    function automatic data_t rand_word();
        case ($urandom_range(0, 4))
            0:       return '1;
            1:       return '0;
            2:       return data_t'($urandom_range(0, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [7:0] rand_reg();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 3));
        return 8'($urandom);
    endfunction

    function automatic logic [3:0] rand_op();
        if ($urandom_range(0, 99) < 8)
            return 4'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
        return 4'($urandom_range(OP_LOADIMM, OP_HALT));
    endfunction

    // Enter and leave at a falling edge; valid stays high for a following transfer.
    task automatic send_instr(input logic [3:0] op, input data_t imm, input logic [7:0] ra,
                              input logic [7:0] rb, input logic [15:0] tgt);
        in_valid    <= 1'b1;
        mode        <= op;
        immediate   <= imm;
        reg_first   <= ra;
        reg_second  <= rb;
        jump_target <= tgt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(execute_instr(op, imm, ra, rb, tgt));
        @(negedge clk);
    endtask

    task automatic send_rand(input logic [3:0] op);
        send_instr(op, rand_word(), rand_reg(), rand_reg(), 16'($urandom));
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        exec_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual acc_value %h",
                         $time, acc_value);
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                compare_field("acc_value", exp_r.acc, acc_value);
                compare_field("branch_taken", 64'(exp_r.taken), 64'(branch_taken));
                compare_field("branch_address", 64'(exp_r.addr), 64'(branch_address));
                compare_field("print_kind", 64'(exp_r.pkind), 64'(print_kind));
                compare_field("print_value", exp_r.pval, print_value);
                compare_field("status", 64'(exp_r.stat), 64'(status));
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_FREE:   out_ready <= 1'b1;
                    RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        out_ready  <= rx_pattern[0];
                        rx_pattern  = {rx_pattern[0], rx_pattern[7:1]};
                    end
                endcase
            end
        end
    end

    task automatic test_reset_state();
        send_instr(OP_LOADREG, rand_word(), 8'h00, rand_reg(), 16'($urandom));
        send_instr(OP_ADD, rand_word(), 8'hFF, 8'h00, 16'($urandom));
        send_rand(OP_PRINTNUM);
        send_instr(OP_JUMPNZ, rand_word(), rand_reg(), rand_reg(), 16'hFFFF);
        send_instr(OP_LOADREG, rand_word(), 8'hFF, rand_reg(), 16'($urandom));
    endtask

    task automatic test_each_opcode();
        send_instr(OP_LOADIMM, '1, rand_reg(), rand_reg(), 16'($urandom));
        send_instr(OP_STORE, rand_word(), 8'hFF, rand_reg(), 16'($urandom));
        send_rand(OP_INC);
        send_instr(OP_JUMPNZ, rand_word(), rand_reg(), rand_reg(), 16'hFFFF);
        send_rand(OP_DEC);
        send_instr(OP_JUMPNZ, rand_word(), rand_reg(), rand_reg(), 16'hFFFF);
        send_instr(OP_STORE, rand_word(), 8'h00, rand_reg(), 16'($urandom));
        send_instr(OP_LOADIMM, '0, rand_reg(), rand_reg(), 16'($urandom));
        send_instr(OP_ADD, rand_word(), 8'hFF, 8'h00, 16'($urandom));
        send_instr(OP_PRINT, '1, rand_reg(), rand_reg(), 16'($urandom));
        send_rand(OP_PRINTNUM);
        send_rand(OP_HALT);
        send_instr(OP_LOADREG, rand_word(), 8'h00, rand_reg(), 16'($urandom));
        send_rand(OP_INC);
    endtask

    task automatic test_bad_opcodes();
        for (int op = OP_BAD_FIRST; op <= OP_BAD_LAST; op++)
            send_instr(4'(op), '1, 8'hFF, 8'hFF, 16'hFFFF);
    endtask

    task automatic test_backpressure();
        repeat (2)
        begin
            hold_req = 1'b1;
            repeat (30) send_rand(rand_op());
            idle_gap($urandom_range(1, 4));
        end
    endtask

    task automatic test_random();
        int         sent;
        int         burst;
        logic [7:0] r;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst; i++)
            begin
                if ($urandom_range(0, 9) < 3)
                begin
                    r = rand_reg();
                    send_instr(OP_STORE, rand_word(), r, rand_reg(), 16'($urandom));
                    if ($urandom_range(0, 1) == 0)
                        send_instr(OP_LOADREG, rand_word(), r, rand_reg(), 16'($urandom));
                    else
                        send_instr(OP_ADD, rand_word(), rand_reg(), r, 16'($urandom));
                    sent += 2;
                end
                else
                begin
                    send_rand(rand_op());
                    sent++;
                end
            end
            if ($urandom_range(0, 9) == 0)
                rx_mode = rx_mode_t'($urandom_range(RX_FREE, RX_PATTERN));
            if ($urandom_range(0, 39) == 0)
                hold_req = 1'b1;
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = '0;
        immediate      = '0;
        reg_first      = '0;
        reg_second     = '0;
        jump_target    = '0;
        out_ready      = 1'b0;
        hold_req       = 1'b0;
        rx_mode        = RX_RANDOM;
        rx_pattern     = 8'b1101_0110;
        mismatch_count = 0;
        acc_model      = '0;
        foreach (regfile_model[i])
            regfile_model[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        idle_gap(2);
        rx_mode = RX_PATTERN;
        test_each_opcode();
        rx_mode = RX_FREE;
        test_bad_opcodes();
        test_backpressure();
        rx_mode = RX_RANDOM;
        test_random();

        idle_gap(1);
        rx_mode = RX_FREE;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ame_pkg.sv
rtl/accumulator_machine_execute_top.sv
tb/testbench.sv
